>>> hw/rtl/ddgc_pkg.sv
// ----------------------------------------------------------------------------
// ddgc_pkg: delay, Doppler and gain channel emulator shared definitions
// Beat types, register indexes, codes, and the constant sine and exponent
// tables used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ddgc_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_LEN        = 1 << SINE_TABLE_BITS;
  localparam int SINE_QUARTER    = SINE_LEN / 4;
  localparam int COUNT_BITS      = 48;
  localparam int FDELAY_BITS     = 17;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int EXP_STEPS       = 10;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_ENABLE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_MODE      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOPPLER_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_MODE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINK_CONSTANT  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DELAY      = 3'd5;

  localparam logic [1:0] DMODE_OFF   = 2'd0;
  localparam logic [1:0] DMODE_LATCH = 2'd1;
  localparam logic [1:0] DMODE_TRACK = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
  localparam logic [1:0] STATUS_DELAY    = 2'd2;

  // log2(10)/20 in Q24.
  localparam logic signed [22:0] LOG2_10_OVER_20 = 23'sd2786635;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic [COUNT_BITS-1:0]         frame_start;
    logic [COUNT_BITS-1:0]         frame_end;
    logic [FDELAY_BITS-1:0]        frame_delay;
    logic [31:0]                   frame_phase_step;
    logic [15:0]                   frame_path_loss;
    logic [1:0]                    frame_quality;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          expired;
    logic [1:0]                    quality;
    logic [1:0]                    status;
    logic                          frame_dropped;
  } out_beat_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  start;
    logic [COUNT_BITS-1:0]  stop;
    logic [FDELAY_BITS-1:0] delay;
    logic [PHASE_BITS-1:0]  step;
    logic [15:0]            loss;
    logic [1:0]             grade;
  } frame_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_HEAD,
    ST_READ,
    ST_ROT,
    ST_EXP,
    ST_MANT,
    ST_SCALE,
    ST_DONE
  } ddgc_state_t;

  typedef logic signed [16:0] sine_rom_t [SINE_LEN];

  // 2^(2^-(j+1)) for entry j, in Q30.
  localparam logic [30:0] EXP_STEP [EXP_STEPS] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468888 };

  localparam longint CORDIC_X0    = 64'sd652032874;
  localparam int     CORDIC_STEPS = 28;
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163,
    64'sd1335087, 64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443,
    64'sd41722, 64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304,
    64'sd652, 64'sd326, 64'sd163, 64'sd81, 64'sd41, 64'sd20, 64'sd10, 64'sd5 };

  function automatic longint to_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // Quadrant-reduced CORDIC, evaluated only while the ROM is elaborated.
  function automatic logic signed [16:0] cordic_sin(input logic [31:0] ang);
    longint     x;
    longint     y;
    longint     z;
    longint     dx;
    longint     dy;
    longint     c;
    longint     s;
    longint     r;
    logic [1:0] q;
    q = ang[31:30];
    x = CORDIC_X0;
    y = 64'sd0;
    z = longint'({34'd0, ang[29:0]});
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    c = to_q15(x);
    s = to_q15(y);
    case (q)
      2'd0:    r = s;
      2'd1:    r = c;
      2'd2:    r = -s;
      default: r = -c;
    endcase
    return 17'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int k = 0; k < SINE_LEN; k++) begin
      t[k] = cordic_sin(32'(k) << (32 - SINE_TABLE_BITS));
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> hw/rtl/delay_doppler_gain_channel_top.sv
// A sample beat runs through the sequencer, whose pop state first retires each
// queued frame whose successor has started. No new beat is taken until the sample
// is through, paced by the ten-step serial exponent loop, the shared multiply steps
// and any output stall. Samples with no frame or an excessive delay go from the head
// state straight to done. Reset clears control state, empties the frame queue and
// restores config; the history memory is not cleared.
// ----------------------------------------------------------------------------
// delay_doppler_gain_channel_top: channel emulator with delay, Doppler, gain
// Stores samples in a history memory, reads them back delayed, rotates them
// by a phase accumulator and scales them by a path gain, all under a frame
// queue of channel parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_doppler_gain_channel_top #(
  parameter int MAX_DELAY   = 65535,
  parameter int FRAME_QUEUE = 4
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_valid,
  output logic                                       in_stall,
  input  wire  ddgc_pkg::in_beat_t                   in_data,
  output logic                                       out_valid,
  input  wire                                        out_stall,
  output ddgc_pkg::out_beat_t                        out_data,
  input  wire                                        cfg_valid,
  output logic                                       cfg_ready,
  input  wire  [ddgc_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  wire  [ddgc_pkg::CFG_DATA_BITS-1:0]         cfg_data
);

  // History depth is one more than the longest delay; the write pointer
  // tracks the sample count modulo that depth.
  localparam int HIST_LEN = MAX_DELAY + 1;
  localparam int AW       = $clog2(HIST_LEN);
  localparam int QW       = $clog2(FRAME_QUEUE + 1);
  localparam int QIW      = $clog2(FRAME_QUEUE);
  // Width that holds both a frame delay and any history address, plus a carry.
  localparam int DW       = ((AW > ddgc_pkg::FDELAY_BITS) ? AW : ddgc_pkg::FDELAY_BITS) + 1;
  localparam int SB       = ddgc_pkg::SAMPLE_BITS;
  localparam int CB       = ddgc_pkg::COUNT_BITS;
  localparam int SINE_IDX_W = ddgc_pkg::SINE_TABLE_BITS;

  // Configuration registers. Writes must arrive only while the block is idle;
  // the user ensures this, the block does not enforce it. The port is always ready.
  logic        gain_en_r;
  logic        gain_mode_r;
  logic        dop_en_r;
  logic [1:0]  dmode_r;
  logic [15:0] link_r;
  logic [15:0] maxd_r;

  // Control state.
  ddgc_pkg::ddgc_state_t state_r, state_nxt;
  logic [3:0]            step_r, step_nxt;
  logic [QW-1:0]         fill_r;
  logic                  dropped_r;
  logic [CB-1:0]         count_r;
  logic [AW-1:0]         wptr_r;
  logic [ddgc_pkg::PHASE_BITS-1:0] phase_r;
  logic                  lvalid_r;
  logic [ddgc_pkg::FDELAY_BITS-1:0] ldelay_r;
  logic                  out_valid_r;

  // Frame queue; entry zero is the frame in use.
  ddgc_pkg::frame_ent_t  q_r [FRAME_QUEUE];

  // Datapath registers.
  logic [2*SB-1:0]       hist_mem [HIST_LEN];
  logic [2*SB-1:0]       rd_data_r;
  logic                  zero_r;
  logic signed [16:0]    sin_r;
  logic signed [16:0]    cos_r;
  logic signed [40:0]    gprod_r;
  logic signed [SB-1:0]  xr_r;
  logic signed [SB-1:0]  xi_r;
  logic signed [33:0]    rr_r;
  logic signed [33:0]    ri_r;
  logic [31:0]           m_r;
  logic [21:0]           m20_r;
  logic [9:0]            fr_r;
  logic signed [8:0]     n_r;
  logic signed [56:0]    p_r;
  logic signed [SB-1:0]  res_re_r;
  logic signed [SB-1:0]  res_im_r;
  logic                  res_exp_r;
  logic [1:0]            res_qual_r;
  logic [1:0]            res_status_r;
  logic                  phase_upd_r;
  ddgc_pkg::out_beat_t   out_data_r;

  // Handshake decodes.
  logic in_acc;
  logic out_free;
  logic sample_acc;
  logic frame_acc;
  logic cfg_acc;

  assign in_stall   = (state_r != ddgc_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign sample_acc = in_acc && (in_data.kind == ddgc_pkg::KIND_SAMPLE);
  assign frame_acc  = in_acc && (in_data.kind == ddgc_pkg::KIND_FRAME);
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Frame insert: a frame whose start is not after the newest queued start
  // is dropped silently; a full queue refuses the frame and sets the sticky flag.
  logic [QW-1:0] tail_w;
  logic          frame_late;
  logic          queue_full;
  assign tail_w     = fill_r - QW'(1);
  assign frame_late = (fill_r != '0) && (in_data.frame_start <= q_r[tail_w[QIW-1:0]].start);
  assign queue_full = (fill_r >= QW'(FRAME_QUEUE));

  // The head frame retires while the next one has already started.
  logic pop_go;
  assign pop_go = (fill_r >= QW'(2)) && (q_r[1].start <= count_r);

  // Delay selection and limit check for the head frame.
  ddgc_pkg::frame_ent_t              head;
  logic [ddgc_pkg::FDELAY_BITS-1:0]  delay_sel;
  logic [DW-1:0]                     delay_ext;
  logic [DW-1:0]                     limit_ext;
  logic                              delay_big;
  logic [DW-1:0]                     wptr_ext;
  logic [DW-1:0]                     raddr_ext;
  logic [AW-1:0]                     raddr;
  logic signed [17:0]                gdb;
  logic signed [18:0]                e10;
  logic [SINE_IDX_W-1:0]             sin_idx;
  logic [SINE_IDX_W-1:0]             cos_idx;

  assign head = q_r[0];

  always_comb begin
    case (dmode_r)
      ddgc_pkg::DMODE_OFF:   delay_sel = '0;
      ddgc_pkg::DMODE_LATCH: delay_sel = lvalid_r ? ldelay_r : head.delay;
      default:               delay_sel = head.delay;
    endcase
  end

  assign delay_ext = DW'(delay_sel);
  assign limit_ext = (DW'(maxd_r) < DW'(MAX_DELAY)) ? DW'(maxd_r) : DW'(MAX_DELAY);
  assign delay_big = delay_ext > limit_ext;
  assign wptr_ext  = DW'(wptr_r);
  assign raddr_ext = (wptr_ext >= delay_ext) ? (wptr_ext - delay_ext)
                                             : (wptr_ext + DW'(HIST_LEN) - delay_ext);
  assign raddr     = raddr_ext[AW-1:0];

  // Gain in dB, Q8.8: link constant (or zero) minus path loss.
  assign gdb = (gain_mode_r ? 18'sd0 : 18'(signed'(link_r))) - $signed({2'b00, head.loss});
  // log2 of the gain rounded to Q10: integer part n and a 10-bit fraction.
  assign e10 = 19'((gprod_r + 41'sd2097152) >>> 22);

  assign sin_idx = phase_r[ddgc_pkg::PHASE_BITS-1 -: SINE_IDX_W];
  assign cos_idx = sin_idx + SINE_IDX_W'(ddgc_pkg::SINE_QUARTER);

  // Shared multiply operands.
  logic [62:0]         mprod;
  logic signed [22:0]  m20s;
  assign mprod = 63'(m_r) * 63'(ddgc_pkg::EXP_STEP[step_r]) + 63'(64'd1 << 29);
  assign m20s  = $signed({1'b0, m20_r});

  // Round half up by 2^(35-n) and saturate to the sample width.
  function automatic logic signed [SB-1:0] round_sat(input logic signed [56:0] p,
                                                    input logic signed [8:0] n);
    int     sh;
    longint pv;
    longint r;
    pv = longint'(p);
    sh = 35 - int'(n);
    if (sh >= 63) r = 64'sd0;
    else r = (pv + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > longint'((64'sd1 <<< (SB - 1)) - 1)) r = (64'sd1 <<< (SB - 1)) - 1;
    if (r < -longint'(64'sd1 <<< (SB - 1))) r = -(64'sd1 <<< (SB - 1));
    return SB'(r);
  endfunction

  // Sequencer: next state and step counter.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ddgc_pkg::ST_IDLE: begin
        if (sample_acc) state_nxt = ddgc_pkg::ST_POP;
      end
      ddgc_pkg::ST_POP: begin
        if (!pop_go) state_nxt = ddgc_pkg::ST_HEAD;
      end
      ddgc_pkg::ST_HEAD: begin
        if ((fill_r == '0) || delay_big) state_nxt = ddgc_pkg::ST_DONE;
        else state_nxt = ddgc_pkg::ST_READ;
      end
      ddgc_pkg::ST_READ: begin
        state_nxt = ddgc_pkg::ST_ROT;
        step_nxt  = '0;
      end
      ddgc_pkg::ST_ROT: begin
        if (step_r == 4'd3) begin
          state_nxt = ddgc_pkg::ST_EXP;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ddgc_pkg::ST_EXP: begin
        if (step_r == 4'(ddgc_pkg::EXP_STEPS - 1)) begin
          state_nxt = ddgc_pkg::ST_MANT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ddgc_pkg::ST_MANT: begin
        state_nxt = ddgc_pkg::ST_SCALE;
        step_nxt  = '0;
      end
      ddgc_pkg::ST_SCALE: begin
        if (step_r == 4'd2) state_nxt = ddgc_pkg::ST_DONE;
        else step_nxt = step_r + 4'd1;
      end
      ddgc_pkg::ST_DONE: begin
        if (out_free) state_nxt = ddgc_pkg::ST_IDLE;
      end
      default: state_nxt = ddgc_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddgc_pkg::ST_IDLE;
      step_r      <= '0;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      count_r     <= '0;
      wptr_r      <= '0;
      phase_r     <= '0;
      lvalid_r    <= 1'b0;
      ldelay_r    <= '0;
      out_valid_r <= 1'b0;
      gain_en_r   <= 1'b1;
      gain_mode_r <= 1'b0;
      dop_en_r    <= 1'b1;
      dmode_r     <= ddgc_pkg::DMODE_TRACK;
      link_r      <= '0;
      maxd_r      <= 16'hFFFF;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      if (cfg_acc) begin
        unique case (cfg_index)
          ddgc_pkg::CFG_GAIN_ENABLE:    gain_en_r   <= cfg_data[0];
          ddgc_pkg::CFG_GAIN_MODE:      gain_mode_r <= cfg_data[0];
          ddgc_pkg::CFG_DOPPLER_ENABLE: dop_en_r    <= cfg_data[0];
          ddgc_pkg::CFG_DELAY_MODE:     dmode_r     <= cfg_data[1:0];
          ddgc_pkg::CFG_LINK_CONSTANT:  link_r      <= cfg_data;
          ddgc_pkg::CFG_MAX_DELAY:      maxd_r      <= cfg_data;
          default: ;
        endcase
      end

      if (frame_acc && !frame_late) begin
        if (queue_full) dropped_r <= 1'b1;
        else fill_r <= fill_r + QW'(1);
      end

      if ((state_r == ddgc_pkg::ST_POP) && pop_go) fill_r <= fill_r - QW'(1);

      if ((state_r == ddgc_pkg::ST_HEAD) && (fill_r != '0) &&
          (dmode_r == ddgc_pkg::DMODE_LATCH) && !lvalid_r) begin
        lvalid_r <= 1'b1;
        ldelay_r <= head.delay;
      end

      if ((state_r == ddgc_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
        count_r     <= count_r + CB'(1);
        // The history index follows the count, which also wraps at 2^48.
        if ((count_r == {CB{1'b1}}) || (wptr_r == AW'(MAX_DELAY))) wptr_r <= '0;
        else wptr_r <= wptr_r + AW'(1);
        if (phase_upd_r) phase_r <= phase_r + head.step;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // History memory: written at the accept edge, read back later, so a
  // zero delay returns the sample just written.
  always_ff @(posedge clk) begin
    if (sample_acc) hist_mem[wptr_r] <= {in_data.sample_re, in_data.sample_im};
    if (state_r == ddgc_pkg::ST_HEAD) rd_data_r <= hist_mem[raddr];
  end

  // Queue payload and datapath.
  always_ff @(posedge clk) begin
    if (frame_acc && !frame_late && !queue_full) begin
      q_r[fill_r[QIW-1:0]] <= '{start: in_data.frame_start, stop: in_data.frame_end,
                               delay: in_data.frame_delay,
                               step:  in_data.frame_phase_step,
                               loss:  in_data.frame_path_loss,
                               grade: in_data.frame_quality};
    end

    unique case (state_r)
      ddgc_pkg::ST_POP: begin
        if (pop_go) begin
          for (int i = 0; i < FRAME_QUEUE - 1; i++) q_r[i] <= q_r[i+1];
        end
      end
      ddgc_pkg::ST_HEAD: begin
        res_re_r    <= '0;
        res_im_r    <= '0;
        sin_r       <= ddgc_pkg::SINE_ROM[sin_idx];
        cos_r       <= ddgc_pkg::SINE_ROM[cos_idx];
        gprod_r     <= 41'(gdb) * 41'(ddgc_pkg::LOG2_10_OVER_20);
        zero_r      <= count_r < CB'(delay_sel);
        phase_upd_r <= (fill_r != '0) && !delay_big && dop_en_r;
        if (fill_r == '0) begin
          res_status_r <= ddgc_pkg::STATUS_NO_FRAME;
          res_exp_r    <= 1'b0;
          res_qual_r   <= '0;
        end else begin
          res_status_r <= delay_big ? ddgc_pkg::STATUS_DELAY : ddgc_pkg::STATUS_OK;
          res_exp_r    <= head.stop < count_r;
          res_qual_r   <= head.grade;
        end
      end
      ddgc_pkg::ST_READ: begin
        xr_r <= zero_r ? '0 : $signed(rd_data_r[2*SB-1:SB]);
        xi_r <= zero_r ? '0 : $signed(rd_data_r[SB-1:0]);
        m_r  <= 32'd1 << 30;
        if (gain_en_r) begin
          n_r  <= e10[18:10];
          fr_r <= e10[9:0];
        end else begin
          n_r  <= '0;
          fr_r <= '0;
        end
      end
      ddgc_pkg::ST_ROT: begin
        if (dop_en_r) begin
          case (step_r)
            4'd0:    rr_r <= 34'(xr_r) * 34'(cos_r);
            4'd1:    rr_r <= rr_r - 34'(xi_r) * 34'(sin_r);
            4'd2:    ri_r <= 34'(xr_r) * 34'(sin_r);
            default: ri_r <= ri_r + 34'(xi_r) * 34'(cos_r);
          endcase
        end else if (step_r == 4'd0) begin
          rr_r <= 34'(xr_r) <<< 15;
          ri_r <= 34'(xi_r) <<< 15;
        end
      end
      ddgc_pkg::ST_EXP: begin
        if (fr_r[4'd9 - step_r]) m_r <= 32'(mprod >> 30);
      end
      ddgc_pkg::ST_MANT: begin
        m20_r <= 22'((m_r + 32'd512) >> 10);
      end
      ddgc_pkg::ST_SCALE: begin
        case (step_r)
          4'd0: p_r <= 57'(rr_r) * 57'(m20s);
          4'd1: begin
            res_re_r <= round_sat(p_r, n_r);
            p_r      <= 57'(ri_r) * 57'(m20s);
          end
          default: res_im_r <= round_sat(p_r, n_r);
        endcase
      end
      ddgc_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_r <= '{out_re: res_re_r, out_im: res_im_r, expired: res_exp_r,
                          quality: res_qual_r, status: res_status_r,
                          frame_dropped: dropped_r};
        end
      end
      default: ;
    endcase
  end

  // The queue never holds more frames than it has room for.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QW'(FRAME_QUEUE))
    else $error("frame queue overfilled");

  // The history write pointer stays inside the memory.
  a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= AW'(MAX_DELAY))
    else $error("history pointer out of range");

  // A no-frame result is only produced with an empty queue.
  a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddgc_pkg::ST_DONE && res_status_r == ddgc_pkg::STATUS_NO_FRAME)
      |-> fill_r == '0)
    else $error("no-frame status with a queued frame");

  // Each delivered result advances the sample count by exactly one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddgc_pkg::ST_DONE && out_free) |=> count_r == $past(count_r) + CB'(1))
    else $error("sample count did not advance");

endmodule

`default_nettype wire
